// ===== hdl/int32_to_decimal_ascii_unit_macros.svh =====
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_unit assertion macros
// shared property forms for the checker, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define I2DA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define I2DA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// widths, character codes, state codes and cell control for the decimal
// text formatter
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 8;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   localparam int NDIG_WIDTH  = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJUST     = 4'd3;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   typedef struct packed {
      logic clear;
      logic convert;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== hdl/i2da_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// i2da_bcd_cell
// one decimal digit of the conversion row: add-3 adjust and shift during
// conversion, digit move toward the top while leading zeros are skipped and during output
// ----------------------------------------------------------------------------
module i2da_bcd_cell
   import i2da_pkg::*;
(
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic                   bit_in,
   input  logic [DIGIT_WIDTH-1:0] digit_in,
   output logic [DIGIT_WIDTH-1:0] digit,
   output logic                   carry_out
);

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in_next;
   logic [DIGIT_WIDTH-1:0] adjusted;

   assign adjusted  = (digit_ff >= DIGIT_ADJUST_MIN) ? digit_ff + DIGIT_ADJUST : digit_ff;
   assign carry_out = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.convert) begin
         digit_in_next = {adjusted[DIGIT_WIDTH-2:0], bit_in};
      end else if (ctrl.shift) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

// ===== hdl/int32_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_unit
// signed 32-bit value in, its decimal ASCII text out one character per transfer
// ----------------------------------------------------------------------------
// req channel: one signed value per transfer on req_value. rsp channel: one
// character per transfer on rsp_char_code, with rsp_last on the final one.
// A negative value starts with '-', digits follow most significant first with
// no leading zeros, and zero gives a single '0'.
// The magnitude is shifted bit-serially into a row of ten BCD cells, one bit
// per cycle. Leading zeros are then dropped by moving the row up one digit
// per cycle, and characters then leave at one per cycle while the receiver
// is ready: the sign first for a negative value, then digits from the top cell.
// Skipped zeros and emitted digits always add up to ten. The block takes no
// new value until req_ready rises again, which happens as soon as the last
// character sits in the output register.
// A stalled receiver holds the output register and the row waits with it.
// Reset clears the control and empties the output register.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_unit
   import i2da_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                   rsp_last
);

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [NDIG_WIDTH-1:0]  ndig_ff, ndig_in;
   logic                   sign_ff, sign_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   cell_ctrl_type          cell_ctrl;
   logic                   req_xfer;
   logic                   out_free;
   logic [DIGIT_WIDTH-1:0] digits [NUM_DIGITS];
   logic                   carry  [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0] top_digit;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign top_digit     = digits[NUM_DIGITS-1];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   // row of digit cells, least significant at index 0
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
         i2da_bcd_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .bit_in    (mag_ff[VALUE_WIDTH-1]),
            .digit_in  ('0),
            .digit     (digits[i]),
            .carry_out (carry[i])
         );
      end else begin : g_up
         i2da_bcd_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .bit_in    (carry[i-1]),
            .digit_in  (digits[i-1]),
            .digit     (digits[i]),
            .carry_out (carry[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cell_ctrl    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sign_in         = req_value[VALUE_WIDTH-1];
               mag_in          = req_value[VALUE_WIDTH-1] ? ~req_value + 1'b1 : req_value;
               cnt_in          = '0;
               cell_ctrl.clear = 1'b1;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_ctrl.convert = 1'b1;
            mag_in            = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in            = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               ndig_in  = NDIG_WIDTH'(NUM_DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros but keep one digit for a zero value
            if (top_digit == '0 && ndig_ff != NDIG_WIDTH'(1)) begin
               cell_ctrl.shift = 1'b1;
               ndig_in         = ndig_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in     = CHAR_ZERO + CHAR_WIDTH'(top_digit);
                  rsp_last_in     = (ndig_ff == NDIG_WIDTH'(1));
                  cell_ctrl.shift = 1'b1;
                  ndig_in         = ndig_ff - 1'b1;
                  if (ndig_ff == NDIG_WIDTH'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      ndig_ff     <= ndig_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== hdl/i2da_checker.sv =====
// ----------------------------------------------------------------------------
// i2da_checker
// port-level checks for the decimal text formatter, bound to the top level
// ----------------------------------------------------------------------------
`include "int32_to_decimal_ascii_unit_macros.svh"

module i2da_checker
   import i2da_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CHAR_WIDTH-1:0]  rsp_char_code,
   input logic                   rsp_last
);

   logic                  rsp_stall;
   logic [CHAR_WIDTH:0]   rsp_word;
   logic                  char_ok;
   logic                  req_xfer;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_last, rsp_char_code};
   assign char_ok   = (rsp_char_code == CHAR_MINUS) ||
                      (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE);
   assign req_xfer  = req_valid && req_ready;

   // a stalled character holds
   `I2DA_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "rsp changed")

   // only a sign or a digit ever leaves
   `I2DA_ASSERT_IMP(a_char_set, rsp_valid, char_ok, "rsp character out of set")

   // the sign never ends a run
   `I2DA_ASSERT_IMP(a_sign_not_last, rsp_valid && rsp_char_code == CHAR_MINUS, !rsp_last, "sign last")

   // block goes busy after taking a value
   `I2DA_ASSERT_NXT(a_busy_after_req, req_xfer, !req_ready, "ready after req transfer")

endmodule

bind int32_to_decimal_ascii_unit i2da_checker u_i2da_checker (.*);
